### sv/double_ended_priority_queue_defines.svh
// Assertion macros shared by the double-ended priority queue RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DEDPQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DEDPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/dedpq_pkg.sv
// Types and codes for the double-ended priority queue.
// No dependencies; imported by the controller, datapath and top level.
package dedpq_pkg;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_DEL_MAX = 2'd1,
      OP_DEL_MIN = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_LOAD = 3'b100
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

### sv/dedpq_sorted_row.sv
// One sorted row of value cells with parallel insert and front pop.
// No package dependency; instanced twice by dedpq_datapath.
module dedpq_sorted_row #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32,
   parameter bit DESCENDING = 1'b0,
   localparam int COUNT_BITS = $clog2(CAPACITY + 1)
) (
   input  logic                         clock,
   input  logic                         ins_en,
   input  logic                         pop_en,
   input  logic signed [VALUE_BITS-1:0] key,
   input  logic        [COUNT_BITS-1:0] count,
   output logic signed [VALUE_BITS-1:0] front
);

   logic signed [VALUE_BITS-1:0] cell_ff [CAPACITY];
   logic [CAPACITY-1:0]          moves;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                         from_below;
      logic                         at_end;
      logic signed [VALUE_BITS-1:0] below_val;
      logic signed [VALUE_BITS-1:0] above_val;
      logic signed [VALUE_BITS-1:0] cell_in;

      // held entries that sit past the new key move up one place
      assign moves[i] = (COUNT_BITS'(i) < count) &&
                        (DESCENDING ? (cell_ff[i] < key) : (cell_ff[i] > key));
      assign at_end   = (COUNT_BITS'(i) == count);

      if (i == 0) begin : g_first
         assign from_below = 1'b0;
         assign below_val  = cell_ff[i];
      end else begin : g_rest
         assign from_below = moves[i-1];
         assign below_val  = cell_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign above_val = cell_ff[i];
      end else begin : g_inner
         assign above_val = cell_ff[i+1];
      end

      always_comb begin
         cell_in = cell_ff[i];
         if (ins_en) begin
            if (from_below) begin
               cell_in = below_val;
            end else if (moves[i] || at_end) begin
               cell_in = key;
            end
         end else if (pop_en) begin
            cell_in = above_val;
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in;
      end
   end

   assign front = cell_ff[0];

endmodule

### sv/dedpq_datapath.sv
// Datapath: request capture, ascending and descending rows, count, response register.
// Depends on dedpq_pkg, dedpq_sorted_row and the assertion macro header.
`include "double_ended_priority_queue_defines.svh"
module dedpq_datapath
   import dedpq_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32,
   localparam int COUNT_BITS = $clog2(CAPACITY + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   output dp_status_type                status,
   input  logic [1:0]                   req_operation,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [VALUE_BITS-1:0] rsp_max_value,
   output logic signed [VALUE_BITS-1:0] rsp_min_value,
   output logic        [COUNT_BITS-1:0] rsp_entry_count,
   output logic                         rsp_rejected
);

   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(CAPACITY);

   op_type                       op_ff;
   logic signed [VALUE_BITS-1:0] value_ff;
   logic        [COUNT_BITS-1:0] count_ff, count_in;
   logic                         rejected_ff, rejected_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_BITS-1:0] max_ff, min_ff;
   logic        [COUNT_BITS-1:0] entry_count_ff;
   logic                         rsp_rejected_ff;

   logic                         full, empty;
   logic                         do_insert, pop_asc, pop_desc;
   logic signed [VALUE_BITS-1:0] asc_front, desc_front;

   assign full  = (count_ff == FULL_COUNT);
   assign empty = (count_ff == '0);

   always_comb begin
      do_insert   = 1'b0;
      pop_asc     = 1'b0;
      pop_desc    = 1'b0;
      count_in    = count_ff;
      rejected_in = rejected_ff;
      if (cmd.exec) begin
         rejected_in = 1'b0;
         case (op_ff)
            OP_INSERT: begin
               if (full) begin
                  rejected_in = 1'b1;
               end else begin
                  do_insert = 1'b1;
                  count_in  = count_ff + 1'b1;
               end
            end
            OP_DEL_MAX: begin
               if (empty) begin
                  rejected_in = 1'b1;
               end else begin
                  pop_desc = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_DEL_MIN: begin
               if (empty) begin
                  rejected_in = 1'b1;
               end else begin
                  pop_asc  = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               rejected_in = 1'b0;
            end
         endcase
      end
   end

   // both rows hold the same values; each drops its own front only
   dedpq_sorted_row #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS),
      .DESCENDING (1'b0)
   ) u_asc_row (
      .clock  (clock),
      .ins_en (do_insert),
      .pop_en (pop_asc),
      .key    (value_ff),
      .count  (count_ff),
      .front  (asc_front)
   );

   dedpq_sorted_row #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS),
      .DESCENDING (1'b1)
   ) u_desc_row (
      .clock  (clock),
      .ins_en (do_insert),
      .pop_en (pop_desc),
      .key    (value_ff),
      .count  (count_ff),
      .front  (desc_front)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rejected_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rejected_ff  <= rejected_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_operation);
         value_ff <= req_value;
      end
      if (cmd.load) begin
         max_ff          <= empty ? '0 : desc_front;
         min_ff          <= empty ? '0 : asc_front;
         entry_count_ff  <= count_ff;
         rsp_rejected_ff <= rejected_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_max_value   = max_ff;
   assign rsp_min_value   = min_ff;
   assign rsp_entry_count = entry_count_ff;
   assign rsp_rejected    = rsp_rejected_ff;

   `DEDPQ_ASSERT_NEXT(a_insert_counts, clock, reset,
      cmd.exec && (op_ff == OP_INSERT) && !full,
      count_ff == $past(count_ff) + 1'b1, "insert did not bump count")
   `DEDPQ_ASSERT_IMPLY(a_load_when_free, clock, reset,
      cmd.load, !(rsp_valid_ff && rsp_stall), "response overwritten while held")
   `DEDPQ_ASSERT_IMPLY(a_min_not_above_max, clock, reset,
      rsp_valid_ff && (entry_count_ff != '0), min_ff <= max_ff, "min above max")

endmodule

### sv/dedpq_ctrl.sv
// Controller: one-hot sequencer for capture, update and response load.
// Depends on dedpq_pkg and the assertion macro header.
`include "double_ended_priority_queue_defines.svh"
module dedpq_ctrl
   import dedpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DEDPQ_ASSERT_NEXT(a_exec_then_load, clock, reset,
      cmd.exec, state_ff == ST_LOAD, "update not followed by load")

endmodule

### sv/double_ended_priority_queue.sv
// Double-ended priority queue of signed values with bounded capacity.
// Request channel (req_): operation (insert, delete largest, delete smallest,
// query) and a value for inserts. Response channel (rsp_): largest and
// smallest values held after the request (0 when empty), the entry count,
// and a rejected flag for an insert when full or a delete when empty.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// After a request is accepted, the sorted rows are updated, then the response
// is loaded when the output is free. The sequencer takes one request at a
// time (capture, update, load); no new request is taken until it is loaded.
// Values sit in two sorted shift-register rows (ascending and descending)
// updated in parallel, so largest and smallest are always at fixed cells.
// A request may be accepted while the previous response is still held.
// If the receiver stalls, the response holds and the sequencer waits before
// loading the next response, then stalls new requests.
// Reset (synchronous, active high) empties the queue and drops any response.
// Dependencies: dedpq_pkg, dedpq_ctrl, dedpq_datapath, dedpq_sorted_row.
module double_ended_priority_queue
   import dedpq_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32,
   localparam int COUNT_BITS = $clog2(CAPACITY + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [VALUE_BITS-1:0] rsp_max_value,
   output logic signed [VALUE_BITS-1:0] rsp_min_value,
   output logic        [COUNT_BITS-1:0] rsp_entry_count,
   output logic                         rsp_rejected
);

   dp_cmd_type    cmd;
   dp_status_type status;

   dedpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dedpq_datapath #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_max_value   (rsp_max_value),
      .rsp_min_value   (rsp_min_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_rejected    (rsp_rejected)
   );

endmodule
